>>> sv/rpn_stack_evaluator_core_assert.svh
// Assertion macros for the RPN stack evaluator checker.
// Expects signals named clk and rst in the scope of each use.
`ifndef RPN_STACK_EVALUATOR_CORE_ASSERT_SVH
`define RPN_STACK_EVALUATOR_CORE_ASSERT_SVH

// same-cycle implication
`define RSE_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define RSE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> sv/rse_pkg.sv
// Shared types and constants for the RPN stack evaluator.
// No dependencies.
`timescale 1ns / 1ps

package rse_pkg;

  localparam int DATA_W              = 32;
  localparam int LEVEL_W             = 5;
  localparam int DEFAULT_STACK_DEPTH = 16;

  localparam logic [2:0] OP_PUSH = 3'd0;
  localparam logic [2:0] OP_ADD  = 3'd1;
  localparam logic [2:0] OP_SUB  = 3'd2;
  localparam logic [2:0] OP_MUL  = 3'd3;
  localparam logic [2:0] OP_POW  = 3'd4;
  localparam logic [2:0] OP_EQ   = 3'd5;

  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_UNDER = 2'd1;
  localparam logic [1:0] STAT_OVER  = 2'd2;

  typedef enum logic [1:0] {
    CMD_HOLD,
    CMD_PUSH,
    CMD_POP
  } cell_cmd_t;

  typedef struct packed {
    logic start;
    logic pow;
  } alu_req_t;

endpackage

>>> sv/rse_cell.sv
// One stack entry of the shift-register stack.
// Depends on rse_pkg.
`timescale 1ns / 1ps

module rse_cell (
  input  logic                      clk,
  input  rse_pkg::cell_cmd_t        cmd,
  input  logic [rse_pkg::DATA_W-1:0] up_data,
  input  logic [rse_pkg::DATA_W-1:0] down_data,
  output logic [rse_pkg::DATA_W-1:0] data
);
  import rse_pkg::*;

  always_ff @(posedge clk) begin
    case (cmd)
      CMD_PUSH: data <= up_data;
      CMD_POP:  data <= down_data;
      default:  data <= data;
    endcase
  end

endmodule

>>> sv/rse_alu.sv
// Serial square-and-multiply unit; also serves plain multiply in one step.
// Depends on rse_pkg.
`timescale 1ns / 1ps

module rse_alu (
  input  logic                       clk,
  input  logic                       rst,
  input  rse_pkg::alu_req_t          req,
  input  logic [rse_pkg::DATA_W-1:0] lhs,
  input  logic [rse_pkg::DATA_W-1:0] rhs,
  output logic                       done,
  output logic [rse_pkg::DATA_W-1:0] result
);
  import rse_pkg::*;

  localparam int EXP_W = DATA_W - 1;

  logic [DATA_W-1:0]   acc;
  logic [DATA_W-1:0]   sq;
  logic [EXP_W-1:0]    ex;
  logic                run;
  logic [DATA_W-1:0]   acc_prod;
  logic [DATA_W-1:0]   sq_prod;
  logic [EXP_W-1:0]    ex_load;

  assign acc_prod = acc * sq;
  assign sq_prod  = sq * sq;
  assign ex_load  = req.pow ? (rhs[DATA_W-1] ? '0 : rhs[EXP_W-1:0])
                            : EXP_W'(1);
  assign result   = acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
    end else if (req.start) begin
      run  <= (ex_load != '0);
      done <= (ex_load == '0);
    end else if (run) begin
      run  <= (ex[EXP_W-1:1] != '0);
      done <= (ex[EXP_W-1:1] == '0);
    end else begin
      done <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      acc <= req.pow ? DATA_W'(1) : lhs;
      sq  <= req.pow ? lhs : rhs;
      ex  <= ex_load;
    end else if (run) begin
      if (ex[0]) begin
        acc <= acc_prod[DATA_W-1:0];
      end
      sq <= sq_prod[DATA_W-1:0];
      ex <= ex >> 1;
    end
  end

endmodule

>>> sv/rpn_stack_evaluator_core.sv
// Top level of the RPN stack evaluator: token decode, cell row and power unit.
// Depends on rse_pkg, rse_cell and rse_alu.
// Each accepted token gives one result, shown for one cycle on result_strobe.
// Push, add, subtract, equals, unused codes and every error give the result
// in the cycle after acceptance, and busy stays low, so a token may be taken
// every cycle. Multiply and power hold busy high while the shared serial
// square-and-multiply unit runs, one exponent bit per cycle up to the highest
// set bit; an exponent of zero or below needs no run step. The stack is a row
// of STACK_DEPTH cells that shift together on push and equals; add, subtract,
// multiply and power write the head and pull the rest toward it. The receiver
// cannot stall results.
`timescale 1ns / 1ps

module rpn_stack_evaluator_core #(
  parameter int STACK_DEPTH = rse_pkg::DEFAULT_STACK_DEPTH
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic [2:0]                  opcode,
  input  logic signed [rse_pkg::DATA_W-1:0] push_value,
  output logic                        result_strobe,
  output logic signed [rse_pkg::DATA_W-1:0] result_value,
  output logic                        is_answer,
  output logic [1:0]                  status,
  output logic [rse_pkg::LEVEL_W-1:0] stack_level
);
  import rse_pkg::*;

  localparam int CW = $clog2(STACK_DEPTH + 1);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_RUN  = 1'b1;

  logic                state;
  logic                state_next;
  logic [CW-1:0]       cnt;
  logic [CW-1:0]       cnt_next;
  logic [CW+LEVEL_W-1:0] cnt_ext;
  cell_cmd_t           cmd_head;
  cell_cmd_t           cmd_rest;
  logic [DATA_W-1:0]   head_in;
  logic [DATA_W-1:0]   cell_data [STACK_DEPTH];
  alu_req_t            alu_req;
  logic                alu_done;
  logic [DATA_W-1:0]   alu_result;
  logic                out_load;
  logic [DATA_W-1:0]   value_next;
  logic                answer_next;
  logic [1:0]          status_next;

  assign busy    = (state == ST_RUN);
  assign cnt_ext = {{LEVEL_W{1'b0}}, cnt_next};

  always_comb begin
    state_next  = state;
    cnt_next    = cnt;
    cmd_head    = CMD_HOLD;
    cmd_rest    = CMD_HOLD;
    head_in     = alu_result;
    alu_req     = '0;
    out_load    = 1'b0;
    value_next  = '0;
    answer_next = 1'b0;
    status_next = STAT_OK;
    if (state == ST_IDLE && start) begin
      out_load = 1'b1;
      case (opcode)
        OP_PUSH: begin
          if (cnt >= CW'(STACK_DEPTH)) begin
            status_next = STAT_OVER;
          end else begin
            cmd_head   = CMD_PUSH;
            cmd_rest   = CMD_PUSH;
            head_in    = push_value;
            cnt_next   = cnt + CW'(1);
            value_next = push_value;
          end
        end
        OP_ADD, OP_SUB, OP_MUL, OP_POW: begin
          if (cnt < CW'(2)) begin
            status_next = STAT_UNDER;
          end else if (opcode inside {OP_MUL, OP_POW}) begin
            out_load      = 1'b0;
            alu_req.start = 1'b1;
            alu_req.pow   = (opcode == OP_POW);
            state_next    = ST_RUN;
          end else begin
            value_next = (opcode == OP_ADD) ? cell_data[1] + cell_data[0]
                                            : cell_data[1] - cell_data[0];
            head_in    = value_next;
            cmd_head   = CMD_PUSH;
            cmd_rest   = CMD_POP;
            cnt_next   = cnt - CW'(1);
          end
        end
        OP_EQ: begin
          if (cnt == '0) begin
            status_next = STAT_UNDER;
          end else begin
            value_next  = cell_data[0];
            answer_next = 1'b1;
            cmd_head    = CMD_POP;
            cmd_rest    = CMD_POP;
            cnt_next    = cnt - CW'(1);
          end
        end
        default: begin
          value_next = '0;
        end
      endcase
    end else if (state == ST_RUN && alu_done) begin
      out_load   = 1'b1;
      value_next = alu_result;
      cmd_head   = CMD_PUSH;
      cmd_rest   = CMD_POP;
      cnt_next   = cnt - CW'(1);
      state_next = ST_IDLE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      cnt           <= '0;
      result_strobe <= 1'b0;
      stack_level   <= '0;
    end else begin
      state         <= state_next;
      cnt           <= cnt_next;
      result_strobe <= out_load;
      if (out_load) begin
        stack_level <= cnt_ext[LEVEL_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      result_value <= value_next;
      is_answer    <= answer_next;
      status       <= status_next;
    end
  end

  for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
    rse_cell u_cell (
      .clk       (clk),
      .cmd       ((i == 0) ? cmd_head : cmd_rest),
      .up_data   ((i == 0) ? head_in : cell_data[(i == 0) ? 0 : i - 1]),
      .down_data (cell_data[(i == STACK_DEPTH - 1) ? i : i + 1]),
      .data      (cell_data[i])
    );
  end

  rse_alu u_alu (
    .clk    (clk),
    .rst    (rst),
    .req    (alu_req),
    .lhs    (cell_data[1]),
    .rhs    (cell_data[0]),
    .done   (alu_done),
    .result (alu_result)
  );

endmodule

>>> sv/rse_checker.sv
// Port-level checks on the RPN stack evaluator, bound to the top level.
// Depends on rse_pkg and rpn_stack_evaluator_core_assert.svh.
`timescale 1ns / 1ps
`include "rpn_stack_evaluator_core_assert.svh"

module rse_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        start,
  input logic                        busy,
  input logic [2:0]                  opcode,
  input logic                        result_strobe,
  input logic [1:0]                  status,
  input logic [rse_pkg::LEVEL_W-1:0] stack_level
);
  import rse_pkg::*;

  logic accept;
  logic quick_req;

  assign accept    = start && !busy;
  assign quick_req = accept && opcode != OP_MUL && opcode != OP_POW;

  `RSE_ASSERT_SAME(a_no_result_while_busy, busy, !result_strobe, "result while busy")
  `RSE_ASSERT_NEXT(a_quick_result, quick_req, result_strobe, "missing quick result")
  `RSE_ASSERT_SAME(a_result_ends_busy, $fell(busy) && !$past(rst), result_strobe, "busy ended without result")
  `RSE_ASSERT_SAME(a_error_keeps_level, result_strobe && status != STAT_OK, $stable(stack_level), "level moved on error")

endmodule

bind rpn_stack_evaluator_core rse_checker u_rse_checker (.*);
